[sv/ssce_pkg.sv]
// ssce_pkg: shared constants for the scrolling strip chart engine
// no dependencies; used by the engine top level and its checker

package ssce_pkg;

  localparam int POINTS     = 64;
  localparam int SLOT_W     = $clog2(POINTS);
  localparam int CNT_W      = SLOT_W + 1;
  localparam int SAMPLE_W   = 16;
  localparam int HEIGHT_W   = 8;
  localparam int MODE_W     = 2;

  // scale = SCALE_NUM / span, never more than SCALE_NUM
  localparam int SCALE_NUM  = 100 * 100;
  localparam int SCALE_W    = $clog2(SCALE_NUM + 1);
  localparam int PROD_W     = SAMPLE_W + SCALE_W;

  // height = prod / 100, saturating at 255
  localparam int SAT_LIMIT  = 256 * 100;
  localparam int SAT_W      = $clog2(SAT_LIMIT);
  localparam int RECIP      = 5243;
  localparam int RECIP_W    = 13;
  localparam int RECIP_SH   = 19;
  localparam int RPROD_W    = SAT_W + RECIP_W;

  localparam logic [MODE_W-1:0] MODE_RECORD  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ADVANCE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RENDER  = 2'd2;

endpackage

[sv/ssce_ram.sv]
// ssce_ram: generic single-write, single-read ram with registered read data
// no dependencies

module ssce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[sv/scrolling_strip_chart_engine.sv]
// render: full ring runs a 64-entry min/max scan, a 14-step divider, then one column
// per cycle through a 3-stage column pipe; a filling ring skips the scan.
// record and advance never leave idle. busy stays high for the whole render and results
// leave on out_strobe, one column per cycle, the receiver cannot stall them.
// reset (synchronous, rst_n low) empties the ring: per-entry valid bits make it read zero.
// scrolling_strip_chart_engine: top level, sequencer, divider and column pipe
// depends on ssce_pkg and ssce_ram

module scrolling_strip_chart_engine (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [ssce_pkg::MODE_W-1:0]    in_mode,
  input  logic [ssce_pkg::SAMPLE_W-1:0]  in_sample_value,
  output logic                           out_strobe,
  output logic [ssce_pkg::SLOT_W-1:0]    out_column_index,
  output logic [ssce_pkg::HEIGHT_W-1:0]  out_base_height,
  output logic [ssce_pkg::HEIGHT_W-1:0]  out_contour_height,
  output logic [ssce_pkg::SAMPLE_W-1:0]  out_shown_min,
  output logic [ssce_pkg::SAMPLE_W-1:0]  out_shown_max,
  output logic                           out_last_column
);

  typedef enum logic [2:0] {ST_IDLE, ST_SCAN, ST_SPAN, ST_DIV, ST_COLS} state_t;

  state_t                             state_r, state_nxt;
  logic [ssce_pkg::SLOT_W-1:0]        wslot_r, wslot_nxt;
  logic [ssce_pkg::SLOT_W-1:0]        oslot_r, oslot_nxt;
  logic                               full_r, full_nxt;
  logic [ssce_pkg::SAMPLE_W-1:0]      latest_r, latest_nxt;
  logic [ssce_pkg::SAMPLE_W-1:0]      low_r, low_nxt;
  logic [ssce_pkg::SAMPLE_W-1:0]      high_r, high_nxt;
  logic [ssce_pkg::HEIGHT_W-1:0]      prev_r, prev_nxt;
  logic [ssce_pkg::POINTS-1:0]        valid_r, valid_nxt;

  logic [ssce_pkg::CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [ssce_pkg::CNT_W-1:0]         count_r, count_nxt;
  logic [ssce_pkg::SLOT_W-1:0]        pos_r, pos_nxt;
  logic [ssce_pkg::SAMPLE_W-1:0]      span_r, span_nxt;
  logic [ssce_pkg::SAMPLE_W-1:0]      rem_r, rem_nxt;
  logic [ssce_pkg::SCALE_W-1:0]       quo_r, quo_nxt;
  logic [ssce_pkg::SCALE_W-1:0]       dvd_r, dvd_nxt;
  logic [ssce_pkg::SCALE_W-1:0]       scale_r, scale_nxt;

  // column pipe: tag stage lines up with ram read data, then product stage
  logic                               t_vld_r, t_vld_nxt;
  logic                               t_last_r, t_last_nxt;
  logic [ssce_pkg::SLOT_W-1:0]        t_idx_r, t_idx_nxt;
  logic                               p_vld_r, p_vld_nxt;
  logic                               p_last_r, p_last_nxt;
  logic [ssce_pkg::SLOT_W-1:0]        p_idx_r, p_idx_nxt;
  logic [ssce_pkg::PROD_W-1:0]        prod_r, prod_nxt;

  logic                               o_strobe_r, o_strobe_nxt;
  logic                               o_last_r, o_last_nxt;
  logic [ssce_pkg::SLOT_W-1:0]        o_idx_r, o_idx_nxt;
  logic [ssce_pkg::HEIGHT_W-1:0]      o_base_r, o_base_nxt;
  logic [ssce_pkg::HEIGHT_W-1:0]      o_cont_r, o_cont_nxt;

  logic                               rd_valid_r, rd_valid_nxt;

  logic                               wr_en, rd_en;
  logic [ssce_pkg::SLOT_W-1:0]        rd_addr;
  logic [ssce_pkg::SAMPLE_W-1:0]      ram_q, rd_val;
  logic                               accept;

  logic [ssce_pkg::SAMPLE_W:0]        trial;
  logic                               ge;
  logic [ssce_pkg::SAMPLE_W-1:0]      diff;
  logic [ssce_pkg::RPROD_W-1:0]       rprod;
  logic [ssce_pkg::HEIGHT_W-1:0]      hgt;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);
  assign wr_en  = accept && (in_mode == ssce_pkg::MODE_RECORD);
  assign rd_val = rd_valid_r ? ram_q : '0;

  ssce_ram #(
    .WIDTH (ssce_pkg::SAMPLE_W),
    .DEPTH (ssce_pkg::POINTS)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wslot_r),
    .wr_data (in_sample_value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  // divider step and column arithmetic
  assign trial = {rem_r, dvd_r[ssce_pkg::SCALE_W-1]};
  assign ge    = (trial >= {1'b0, span_r});
  assign diff  = (rd_val > low_r) ? (rd_val - low_r) : '0;
  assign rprod = prod_r[ssce_pkg::SAT_W-1:0] * ssce_pkg::RPROD_W'(ssce_pkg::RECIP);
  assign hgt   = (prod_r >= ssce_pkg::PROD_W'(ssce_pkg::SAT_LIMIT)) ? '1 :
                 rprod[ssce_pkg::RECIP_SH +: ssce_pkg::HEIGHT_W];

  always_comb begin
    state_nxt    = state_r;
    wslot_nxt    = wslot_r;
    oslot_nxt    = oslot_r;
    full_nxt     = full_r;
    latest_nxt   = latest_r;
    low_nxt      = low_r;
    high_nxt     = high_r;
    prev_nxt     = prev_r;
    valid_nxt    = valid_r;
    cnt_nxt      = cnt_r;
    count_nxt    = count_r;
    pos_nxt      = pos_r;
    span_nxt     = span_r;
    rem_nxt      = rem_r;
    quo_nxt      = quo_r;
    dvd_nxt      = dvd_r;
    scale_nxt    = scale_r;
    t_vld_nxt    = 1'b0;
    t_last_nxt   = 1'b0;
    t_idx_nxt    = t_idx_r;
    p_vld_nxt    = 1'b0;
    p_last_nxt   = 1'b0;
    p_idx_nxt    = t_idx_r;
    prod_nxt     = diff * scale_r;
    o_strobe_nxt = 1'b0;
    o_last_nxt   = 1'b0;
    o_idx_nxt    = o_idx_r;
    o_base_nxt   = o_base_r;
    o_cont_nxt   = o_cont_r;
    rd_en        = 1'b0;
    rd_addr      = pos_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_mode)
            ssce_pkg::MODE_RECORD: begin
              latest_nxt         = in_sample_value;
              valid_nxt[wslot_r] = 1'b1;
            end
            ssce_pkg::MODE_ADVANCE: begin
              wslot_nxt = wslot_r + 1'b1;
              if (full_r) begin
                oslot_nxt = oslot_r + 1'b1;
              end else if (wslot_nxt == ssce_pkg::SLOT_W'(ssce_pkg::POINTS - 1)) begin
                full_nxt = 1'b1;
              end
            end
            ssce_pkg::MODE_RENDER: begin
              cnt_nxt = '0;
              if (full_r) begin
                low_nxt   = '1;
                high_nxt  = '0;
                state_nxt = ST_SCAN;
              end else begin
                // while filling only the latest sample moves the window
                if (latest_r < low_r) low_nxt = latest_r;
                if (latest_r > high_r) high_nxt = latest_r;
                state_nxt = ST_SPAN;
              end
            end
            default: ;
          endcase
        end
      end

      ST_SCAN: begin
        if (cnt_r < ssce_pkg::CNT_W'(ssce_pkg::POINTS)) begin
          rd_en      = 1'b1;
          rd_addr    = cnt_r[ssce_pkg::SLOT_W-1:0];
          cnt_nxt    = cnt_r + 1'b1;
          t_vld_nxt  = 1'b1;
          t_last_nxt = (cnt_r == ssce_pkg::CNT_W'(ssce_pkg::POINTS - 1));
        end
        if (t_vld_r) begin
          if (rd_val < low_r) low_nxt = rd_val;
          if (rd_val > high_r) high_nxt = rd_val;
          if (t_last_r) state_nxt = ST_SPAN;
        end
      end

      ST_SPAN: begin
        span_nxt = (high_r > low_r) ? (high_r - low_r) : '0;
        cnt_nxt  = '0;
        if (full_r) begin
          count_nxt = ssce_pkg::CNT_W'(ssce_pkg::POINTS);
          pos_nxt   = oslot_r;
        end else begin
          count_nxt = {1'b0, wslot_r} + 1'b1;
          pos_nxt   = '0;
        end
        rem_nxt = '0;
        quo_nxt = '0;
        dvd_nxt = ssce_pkg::SCALE_W'(ssce_pkg::SCALE_NUM);
        if (span_nxt == '0) begin
          scale_nxt = '0;
          state_nxt = ST_COLS;
        end else begin
          state_nxt = ST_DIV;
        end
      end

      ST_DIV: begin
        // restoring divide, one quotient bit per cycle
        rem_nxt = ge ? ssce_pkg::SAMPLE_W'(trial - {1'b0, span_r})
                     : trial[ssce_pkg::SAMPLE_W-1:0];
        quo_nxt = {quo_r[ssce_pkg::SCALE_W-2:0], ge};
        dvd_nxt = {dvd_r[ssce_pkg::SCALE_W-2:0], 1'b0};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == ssce_pkg::CNT_W'(ssce_pkg::SCALE_W - 1)) begin
          scale_nxt = quo_nxt;
          cnt_nxt   = '0;
          state_nxt = ST_COLS;
        end
      end

      ST_COLS: begin
        if (cnt_r < count_r) begin
          rd_en      = 1'b1;
          rd_addr    = pos_r;
          pos_nxt    = pos_r + 1'b1;
          cnt_nxt    = cnt_r + 1'b1;
          t_vld_nxt  = 1'b1;
          t_idx_nxt  = cnt_r[ssce_pkg::SLOT_W-1:0];
          t_last_nxt = ((cnt_r + 1'b1) == count_r);
        end
        p_vld_nxt  = t_vld_r;
        p_last_nxt = t_last_r;
        if (p_vld_r) begin
          o_strobe_nxt = 1'b1;
          o_last_nxt   = p_last_r;
          o_idx_nxt    = p_idx_r;
          if (hgt >= prev_r) begin
            o_base_nxt = prev_r;
            o_cont_nxt = hgt - prev_r;
          end else begin
            o_base_nxt = hgt;
            o_cont_nxt = prev_r - hgt;
          end
          prev_nxt = hgt;
          if (p_last_r) state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    rd_valid_nxt = rd_en ? valid_r[rd_addr] : rd_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      wslot_r    <= '0;
      oslot_r    <= '0;
      full_r     <= 1'b0;
      latest_r   <= '0;
      low_r      <= '0;
      high_r     <= '0;
      prev_r     <= '0;
      valid_r    <= '0;
      cnt_r      <= '0;
      t_vld_r    <= 1'b0;
      t_last_r   <= 1'b0;
      p_vld_r    <= 1'b0;
      p_last_r   <= 1'b0;
      o_strobe_r <= 1'b0;
      o_last_r   <= 1'b0;
      rd_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      wslot_r    <= wslot_nxt;
      oslot_r    <= oslot_nxt;
      full_r     <= full_nxt;
      latest_r   <= latest_nxt;
      low_r      <= low_nxt;
      high_r     <= high_nxt;
      prev_r     <= prev_nxt;
      valid_r    <= valid_nxt;
      cnt_r      <= cnt_nxt;
      t_vld_r    <= t_vld_nxt;
      t_last_r   <= t_last_nxt;
      p_vld_r    <= p_vld_nxt;
      p_last_r   <= p_last_nxt;
      o_strobe_r <= o_strobe_nxt;
      o_last_r   <= o_last_nxt;
      rd_valid_r <= rd_valid_nxt;
    end
    count_r  <= count_nxt;
    pos_r    <= pos_nxt;
    span_r   <= span_nxt;
    rem_r    <= rem_nxt;
    quo_r    <= quo_nxt;
    dvd_r    <= dvd_nxt;
    scale_r  <= scale_nxt;
    t_idx_r  <= t_idx_nxt;
    p_idx_r  <= p_idx_nxt;
    prod_r   <= prod_nxt;
    o_idx_r  <= o_idx_nxt;
    o_base_r <= o_base_nxt;
    o_cont_r <= o_cont_nxt;
  end

  assign out_strobe         = o_strobe_r;
  assign out_last_column    = o_last_r;
  assign out_column_index   = o_idx_r;
  assign out_base_height    = o_base_r;
  assign out_contour_height = o_cont_r;
  assign out_shown_min      = low_r;
  assign out_shown_max      = high_r;

endmodule

[sv/ssce_checker.sv]
// ssce_checker: port-level assertions for the strip chart engine, plus its bind
// depends on ssce_pkg; attaches to scrolling_strip_chart_engine

module ssce_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           start,
  input logic                           busy,
  input logic [ssce_pkg::MODE_W-1:0]    in_mode,
  input logic [ssce_pkg::SAMPLE_W-1:0]  in_sample_value,
  input logic                           out_strobe,
  input logic [ssce_pkg::SLOT_W-1:0]    out_column_index,
  input logic [ssce_pkg::HEIGHT_W-1:0]  out_base_height,
  input logic [ssce_pkg::HEIGHT_W-1:0]  out_contour_height,
  input logic [ssce_pkg::SAMPLE_W-1:0]  out_shown_min,
  input logic [ssce_pkg::SAMPLE_W-1:0]  out_shown_max,
  input logic                           out_last_column
);

  // a column that is not the last one leaves the engine busy
  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last_column |-> busy)
    else $error("engine idle in the middle of a render");

  // requests other than render complete at once and emit nothing
  a_quick: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_mode != ssce_pkg::MODE_RENDER |=> !busy && !out_strobe)
    else $error("record or advance request misbehaved");

  // a render starts at column zero
  a_first: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_strobe) |-> out_column_index == '0)
    else $error("render did not start at column zero");

  // columns follow one another without gaps
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last_column |=>
      out_strobe && out_column_index == $past(out_column_index) + 1'b1)
    else $error("column sequence broken");

  // base plus contour, the taller of two heights, stays within 255
  a_height: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ({1'b0, out_base_height} + {1'b0, out_contour_height}) <= 9'd255)
    else $error("column heights out of range");

endmodule

bind scrolling_strip_chart_engine ssce_checker u_ssce_checker (.*);
